// File: rtl/core/ffad_pkg.sv
package ffad_pkg;

  localparam int REQ_W        = 2;
  localparam int AMOUNT_W     = 8;
  localparam int HANDLE_IN_W  = 16;
  localparam int STATUS_W     = 2;
  localparam int OUT_HANDLE_W = 15;
  localparam int CFG_W        = 8;

  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEFRAG = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

  typedef struct packed {
    logic [REQ_W-1:0]       req_type;
    logic [AMOUNT_W-1:0]    amount;
    logic [HANDLE_IN_W-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [OUT_HANDLE_W-1:0] handle_out;
  } res_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } eng_ctrl_t;

  typedef struct packed {
    logic ready;
    logic res_valid;
  } eng_stat_t;

endpackage

// File: rtl/core/ffad_engine.sv
module ffad_engine #(
  parameter int CELLS       = 128,
  parameter int HANDLE_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ffad_pkg::eng_ctrl_t        ctrl,
  input  ffad_pkg::req_t             req,
  input  logic [$clog2(CELLS+1)-1:0] mgd,
  output ffad_pkg::eng_stat_t        stat,
  output ffad_pkg::res_t             res
);

  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS+1);
  localparam int NH_W  = HANDLE_BITS + 1;
  localparam int AM_W  = ffad_pkg::AMOUNT_W;
  localparam int HI_W  = ffad_pkg::HANDLE_IN_W;
  localparam int OUT_W = ffad_pkg::OUT_HANDLE_W;
  localparam int KEY_W = (HANDLE_BITS > HI_W) ? HANDLE_BITS : HI_W;
  localparam int AW    = (CNT_W > AM_W) ? CNT_W : AM_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ALLOC_SCAN, S_ALLOC_FILL, S_ERASE_SCAN,
    S_DEFRAG_SCAN, S_DEFRAG_ZERO, S_RESULT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic                   pv_r, pv_nxt;
  logic [IDX_W-1:0]       pidx_r, pidx_nxt;
  logic [AM_W-1:0]        run_r, run_nxt;
  logic [CNT_W-1:0]       dst_r, dst_nxt;
  logic                   hit_r, hit_nxt;
  logic [AM_W-1:0]        amt_r, amt_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [NH_W-1:0]        nh_r, nh_nxt;
  logic [IDX_W-1:0]       fill_r, fill_nxt;
  logic [IDX_W-1:0]       fend_r, fend_nxt;
  ffad_pkg::res_t         res_r, res_nxt;

  logic [HANDLE_BITS-1:0] mem [CELLS];
  logic                   we;
  logic [IDX_W-1:0]       wa;
  logic [HANDLE_BITS-1:0] wd;
  logic [IDX_W-1:0]       ra;
  logic [HANDLE_BITS-1:0] rd_q;

  logic issue;
  logic d_zero;
  logic key_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  assign issue   = (scan_r < mgd);
  assign d_zero  = (rd_q == '0);
  assign key_hit = (KEY_W'(rd_q) == key_r);

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    pv_nxt    = 1'b0;
    pidx_nxt  = pidx_r;
    run_nxt   = run_r;
    dst_nxt   = dst_r;
    hit_nxt   = hit_r;
    amt_nxt   = amt_r;
    key_nxt   = key_r;
    nh_nxt    = nh_r;
    fill_nxt  = fill_r;
    fend_nxt  = fend_r;
    res_nxt   = res_r;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    ra        = '0;

    if (state_r == S_ALLOC_SCAN || state_r == S_ERASE_SCAN || state_r == S_DEFRAG_SCAN) begin
      if (issue) begin
        ra       = scan_r[IDX_W-1:0];
        scan_nxt = scan_r + 1'b1;
        pidx_nxt = scan_r[IDX_W-1:0];
      end
      pv_nxt = issue;
    end

    unique case (state_r)
      S_CLEAR: begin
        we       = 1'b1;
        wa       = scan_r[IDX_W-1:0];
        scan_nxt = scan_r + 1'b1;
        if (scan_r == CNT_W'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (ctrl.start) begin
          amt_nxt  = req.amount;
          key_nxt  = KEY_W'(req.handle_in);
          scan_nxt = '0;
          run_nxt  = '0;
          dst_nxt  = '0;
          hit_nxt  = 1'b0;
          unique case (req.req_type)
            ffad_pkg::REQ_ALLOC: begin
              if (req.amount == '0 || AW'(req.amount) > AW'(mgd) || nh_r[HANDLE_BITS]) begin
                res_nxt   = '{status: ffad_pkg::ST_NULL, handle_out: '0};
                state_nxt = S_RESULT;
              end else begin
                state_nxt = S_ALLOC_SCAN;
              end
            end
            ffad_pkg::REQ_ERASE: begin
              if (req.handle_in[HI_W-1] || req.handle_in == '0) begin
                res_nxt   = '{status: ffad_pkg::ST_ILLEGAL, handle_out: '0};
                state_nxt = S_RESULT;
              end else begin
                state_nxt = S_ERASE_SCAN;
              end
            end
            ffad_pkg::REQ_DEFRAG: begin
              state_nxt = S_DEFRAG_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC_SCAN: begin
        if (pv_r) begin
          if (d_zero) begin
            run_nxt = run_r + 1'b1;
            if (run_r + 8'd1 == amt_r) begin
              state_nxt = S_ALLOC_FILL;
              pv_nxt    = 1'b0;
              fill_nxt  = IDX_W'(AW'(pidx_r) + AW'(1) - AW'(amt_r));
              fend_nxt  = pidx_r;
            end
          end else begin
            run_nxt = '0;
          end
        end else if (!issue) begin
          res_nxt   = '{status: ffad_pkg::ST_NULL, handle_out: '0};
          state_nxt = S_RESULT;
        end
      end
      S_ALLOC_FILL: begin
        we       = 1'b1;
        wa       = fill_r;
        wd       = nh_r[HANDLE_BITS-1:0];
        fill_nxt = fill_r + 1'b1;
        if (fill_r == fend_r) begin
          res_nxt   = '{status: ffad_pkg::ST_OK, handle_out: OUT_W'(nh_r[HANDLE_BITS-1:0])};
          nh_nxt    = nh_r + 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_ERASE_SCAN: begin
        if (pv_r && key_hit) begin
          we      = 1'b1;
          wa      = pidx_r;
          hit_nxt = 1'b1;
        end
        if (!pv_r && !issue) begin
          if (hit_r) begin
            state_nxt = S_IDLE;
          end else begin
            res_nxt   = '{status: ffad_pkg::ST_ILLEGAL, handle_out: '0};
            state_nxt = S_RESULT;
          end
        end
      end
      S_DEFRAG_SCAN: begin
        if (pv_r && !d_zero) begin
          we      = 1'b1;
          wa      = dst_r[IDX_W-1:0];
          wd      = rd_q;
          dst_nxt = dst_r + 1'b1;
        end
        if (!pv_r && !issue) begin
          state_nxt = S_DEFRAG_ZERO;
        end
      end
      S_DEFRAG_ZERO: begin
        if (dst_r < mgd) begin
          we      = 1'b1;
          wa      = dst_r[IDX_W-1:0];
          dst_nxt = dst_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RESULT: begin
        if (ctrl.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      scan_r  <= '0;
      pv_r    <= 1'b0;
      nh_r    <= NH_W'(1);
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      pv_r    <= pv_nxt;
      nh_r    <= nh_nxt;
    end
    pidx_r <= pidx_nxt;
    run_r  <= run_nxt;
    dst_r  <= dst_nxt;
    hit_r  <= hit_nxt;
    amt_r  <= amt_nxt;
    key_r  <= key_nxt;
    fill_r <= fill_nxt;
    fend_r <= fend_nxt;
    res_r  <= res_nxt;
  end

  assign stat.ready     = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_RESULT) && ctrl.out_free;
  assign res            = res_r;

endmodule

// File: rtl/core/first_fit_allocator_defrag_top.sv
// First-fit cell allocator with compaction. The cell table lives in one synchronous RAM of
// CELLS entries that is walked one cell per cycle, so request time follows the managed cell
// count n (cells_in_use, capped at CELLS): an alloc scans up to n cells and then stamps each
// cell of the granted block, an erase scans all n cells, and a defragment copies every used
// cell down over the n cells and then clears the freed cells at the top.
// Requests are handled one at a time; a finished result waits in the output register while
// the next request is taken. After reset all CELLS entries of the RAM are swept to zero, during
// which in_tready stays low; configuration beats are accepted at any time.
module first_fit_allocator_defrag_top #(
  parameter int CELLS       = 128,
  parameter int HANDLE_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // amount [7:0], handle_in [23:8]
  input  logic [1:0]  in_tuser,   // req_type [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // handle_out [14:0], zero [15]
  output logic [1:0]  out_tuser,  // status [1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // cells_in_use [7:0]
);

  localparam int CNT_W = $clog2(CELLS+1);
  localparam int CW    = ffad_pkg::CFG_W;
  localparam int NW    = (CNT_W > CW) ? CNT_W : CW;

  logic [CW-1:0]       cfg_r;
  logic [CNT_W-1:0]    mgd;
  ffad_pkg::req_t      req;
  ffad_pkg::eng_ctrl_t ctrl;
  ffad_pkg::eng_stat_t stat;
  ffad_pkg::res_t      res;
  logic                out_valid_r;
  ffad_pkg::res_t      out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ffad_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      cfg_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign mgd = (NW'(cfg_r) > NW'(CELLS)) ? CNT_W'(CELLS) : CNT_W'(cfg_r);

  assign req.req_type  = in_tuser;
  assign req.amount    = in_tdata[7:0];
  assign req.handle_in = in_tdata[23:8];

  assign in_tready     = stat.ready;
  assign ctrl.start    = in_tvalid && stat.ready;
  assign ctrl.out_free = !out_valid_r || out_tready;

  ffad_engine #(
    .CELLS       (CELLS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .req   (req),
    .mgd   (mgd),
    .stat  (stat),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (stat.res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.handle_out};
  assign out_tuser  = out_res_r.status;

endmodule

// File: rtl/core/ffad_checker.sv
module ffad_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // The table sweep after reset keeps the input closed.
  a_clear_blocks: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != ffad_pkg::REQ_UNUSED |=> !in_tready)
    else $error("second request taken while one is at work");

  a_fail_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ffad_pkg::ST_OK |-> out_tdata == '0)
    else $error("failed request carries a handle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

endmodule

bind first_fit_allocator_defrag_top ffad_checker u_ffad_checker (.*);

// File: tb/sv/first_fit_allocator_defrag_top_tb.sv
module first_fit_allocator_defrag_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELLS = 128;
  localparam int unsigned HANDLE_END = 32768;
  localparam int SETTLE_CYC = 300;
  localparam int LIMIT = 5_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        calm = 1'b0;

  logic [14:0]  owner_tbl [NCELLS];
  int unsigned  handle_ctr = 1;
  logic [7:0]   cells_cfg = ffad_pkg::CFG_RESET;

  ffad_pkg::res_t awaited_answers [$];
  ffad_pkg::req_t req_backlog [$];

  int cycle_cnt = 0;
  int pushed_cnt = 0;
  int taken_cnt = 0;
  int errors = 0;
  int n_grant = 0;
  int n_null = 0;
  int n_illegal = 0;
  int n_compact = 0;
  int n_cfg = 0;

  int phase_cells [10] = '{128, 1, 37, 255, 0, 64, 3, 200, 128, 16};
  int phase_items [10] = '{260, 120, 220, 200, 30, 200, 120, 180, 260, 110};

  first_fit_allocator_defrag_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < NCELLS; i++) owner_tbl[i] = '0;
  end

  function automatic int unsigned managed_cells();
    return (cells_cfg > NCELLS) ? NCELLS : cells_cfg;
  endfunction

  function automatic void model_request(ffad_pkg::req_t rq);
    int unsigned n;
    int unsigned run;
    int unsigned dst;
    bit hit;
    logic [14:0] h;
    ffad_pkg::res_t r;
    n = managed_cells();
    run = 0;
    dst = 0;
    hit = 1'b0;
    r = '{status: ffad_pkg::ST_NULL, handle_out: '0};
    case (rq.req_type)
      ffad_pkg::REQ_ALLOC: begin
        if (rq.amount != 0 && rq.amount <= n && handle_ctr < HANDLE_END) begin
          for (int i = 0; i < n && r.status == ffad_pkg::ST_NULL; i++) begin
            run = (owner_tbl[i] == '0) ? run + 1 : 0;
            if (run == rq.amount) begin
              for (int k = i + 1 - rq.amount; k <= i; k++) owner_tbl[k] = handle_ctr[14:0];
              r = '{status: ffad_pkg::ST_OK, handle_out: handle_ctr[14:0]};
              handle_ctr++;
            end
          end
        end
        if (r.status == ffad_pkg::ST_OK) n_grant++;
        else n_null++;
        awaited_answers = {awaited_answers, r};
      end
      ffad_pkg::REQ_ERASE: begin
        if (!rq.handle_in[15] && rq.handle_in != '0) begin
          for (int i = 0; i < n; i++) begin
            if (owner_tbl[i] == rq.handle_in[14:0]) begin
              owner_tbl[i] = '0;
              hit = 1'b1;
            end
          end
        end
        if (!hit) begin
          n_illegal++;
          r = '{status: ffad_pkg::ST_ILLEGAL, handle_out: '0};
          awaited_answers = {awaited_answers, r};
        end
      end
      ffad_pkg::REQ_DEFRAG: begin
        n_compact++;
        for (int i = 0; i < n; i++) begin
          if (owner_tbl[i] != '0) begin
            h = owner_tbl[i];
            if (dst != i) owner_tbl[i] = '0;
            owner_tbl[dst] = h;
            dst++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(ffad_pkg::res_t got);
    ffad_pkg::res_t want;
    if (awaited_answers.size() == 0) begin
      $error("result with nothing awaited: status %0d handle_out %0d",
             got.status, got.handle_out);
      errors++;
    end else begin
      want = awaited_answers.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.handle_out !== want.handle_out) begin
        $error("handle_out mismatch: expected %0d, actual %0d",
               want.handle_out, got.handle_out);
        errors++;
      end
    end
  endfunction

  function automatic ffad_pkg::req_t mk(logic [1:0] t, logic [7:0] a, logic [15:0] h);
    return '{req_type: t, amount: a, handle_in: h};
  endfunction

  // Picks the owner of a random managed cell so that most erases hit a live block.
  function automatic logic [15:0] live_handle();
    int unsigned n;
    logic [14:0] h;
    n = managed_cells();
    h = '0;
    for (int t = 0; t < 8 && h == '0 && n > 0; t++) h = owner_tbl[$urandom_range(n - 1)];
    if (h == '0) h = (handle_ctr > 1) ? 15'(handle_ctr - 1) : 15'd1;
    return {1'b0, h};
  endfunction

  function automatic ffad_pkg::req_t random_req();
    int unsigned bound;
    int unsigned pick;
    ffad_pkg::req_t rq;
    bound = (managed_cells() == 0) ? 1 : managed_cells();
    rq.amount = 8'($urandom);
    rq.handle_in = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      rq.req_type = ffad_pkg::REQ_ALLOC;
      pick = $urandom_range(99);
      if (pick < 70) rq.amount = 8'($urandom_range(1, (bound / 4 > 1) ? bound / 4 : 1));
      else if (pick < 85) rq.amount = 8'($urandom_range(1, bound));
    end else if (pick < 80) begin
      rq.req_type = ffad_pkg::REQ_ERASE;
      if ($urandom_range(99) < 80) rq.handle_in = live_handle();
    end else if (pick < 94) begin
      rq.req_type = ffad_pkg::REQ_DEFRAG;
    end else begin
      rq.req_type = ffad_pkg::REQ_UNUSED;
    end
    return rq;
  endfunction

  task automatic push_req(input ffad_pkg::req_t rq);
    while (req_backlog.size() > 1) @(negedge clk);
    req_backlog = {req_backlog, rq};
    pushed_cnt++;
  endtask

  // Requests of no result may still be in flight, so wait out a full pass afterwards.
  task automatic settle();
    while (pushed_cnt != taken_cnt || awaited_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_cells(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    cells_cfg = v;
    n_cfg++;
  endtask

  always @(negedge clk) begin : drive
    ffad_pkg::req_t nxt;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
        nxt = req_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {nxt.handle_in, nxt.amount};
        in_tuser <= nxt.req_type;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && (calm || $urandom_range(99) >= 22);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    in_taken <= in_tvalid && in_tready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst_n && out_tvalid && out_tready) check_result({out_tuser, out_tdata[14:0]});
    if (rst_n && in_tvalid && in_tready) begin
      model_request({in_tuser, in_tdata[7:0], in_tdata[23:8]});
      taken_cnt++;
    end
    if (cycle_cnt > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    ffad_pkg::req_t rq;
    int done;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    set_cells(8'd8);
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd0, 16'h0000));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd255, 16'hFFFF));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd3, 16'h0000));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd2, 16'h5A5A));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd4, 16'h0000));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd3, 16'hA5A5));
    push_req(mk(ffad_pkg::REQ_ERASE, 8'd0, 16'd2));
    push_req(mk(ffad_pkg::REQ_ERASE, 8'hFF, 16'd2));
    push_req(mk(ffad_pkg::REQ_ERASE, 8'd0, 16'h0000));
    push_req(mk(ffad_pkg::REQ_ERASE, 8'd0, 16'hFFFF));
    push_req(mk(ffad_pkg::REQ_ERASE, 8'd0, 16'h8000));
    push_req(mk(ffad_pkg::REQ_ERASE, 8'd0, 16'h7FFF));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd1, 16'h0000));
    push_req(mk(ffad_pkg::REQ_DEFRAG, 8'hFF, 16'hFFFF));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd1, 16'h0000));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd1, 16'h0000));
    push_req(mk(ffad_pkg::REQ_UNUSED, 8'($urandom), 16'($urandom)));
    push_req(mk(ffad_pkg::REQ_ERASE, 8'd0, 16'd1));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd2, 16'h0000));

    settle();
    set_cells(8'd0);
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd1, 16'h0000));
    push_req(mk(ffad_pkg::REQ_ERASE, 8'd0, 16'd3));

    settle();
    set_cells(8'd255);
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd128, 16'h0000));
    for (int k = 3; k <= 6; k++) push_req(mk(ffad_pkg::REQ_ERASE, 8'd0, 16'(k)));
    push_req(mk(ffad_pkg::REQ_ALLOC, 8'd128, 16'h0000));

    for (int p = 0; p < 10; p++) begin
      settle();
      set_cells(8'(phase_cells[p]));
      // One whole phase runs with both sides always ready.
      calm = (p == 8);
      done = 0;
      while (done < phase_items[p]) begin
        rq = random_req();
        push_req(rq);
        done++;
      end
    end
    settle();
    calm = 1'b0;

    if (awaited_answers.size() != 0) begin
      $error("%0d results never arrived", awaited_answers.size());
      errors++;
    end
    $display("Sent %0d requests over %0d register settings: %0d grants, %0d no-room, %0d illegal.",
             taken_cnt, n_cfg, n_grant, n_null, n_illegal);
    $display("Ran %0d compactions with managed counts from zero past the table size.", n_compact);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
